/* design/itp_pkg.sv */
// Package for the infix-to-postfix converter.
// Holds sizes, character codes, state and command types and the character
// classification functions. Depends on nothing.
package itp_pkg;

  // Operator stack size and derived widths
  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  // Results allowed per input word; the last slot is kept for the closing word
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  localparam int CHAR_W = 8;
  localparam int STAT_W = 2;
  localparam int PAR_W  = 16;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_MUL    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DIV    = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;

  // Closing status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Class of the current character
  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_SPACE,
    CLS_OPND,
    CLS_OPER,
    CLS_LPAR,
    CLS_RPAR
  } char_cls_t;

  // Source of an emitted character
  typedef enum logic [1:0] {
    SEL_CHAR,
    SEL_SPACE,
    SEL_TOP,
    SEL_CLOSE
  } emit_sel_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EMIT_CH,
    S_POP_RD,
    S_POP_CHK,
    S_POP_SP,
    S_POP_OP,
    S_OP_SP,
    S_PUSH,
    S_FIN_CHK,
    S_CLOSE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      rd;
    logic      pop;
    logic      push;
    logic      clear;
    logic      emit;
    emit_sel_t sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    char_cls_t cls;
    logic      fin;
    logic      sp_zero;
    logic      top_lp;
    logic      top_before;
    logic      room;
  } stat_t;

  function automatic logic is_operand(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_operator(input logic [CHAR_W-1:0] c);
    return c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV ||
           c == CH_CARET;
  endfunction

  // Precedence: 1 for + -, 2 for * /, 3 for ^, 0 otherwise
  function automatic logic [1:0] weight_of(input logic [CHAR_W-1:0] c);
    logic [1:0] w;
    w = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) w = 2'd1;
    else if (c == CH_MUL || c == CH_DIV) w = 2'd2;
    else if (c == CH_CARET) w = 2'd3;
    return w;
  endfunction

  // True when the stacked operator leaves before the incoming one
  function automatic logic pops_before(input logic [CHAR_W-1:0] stacked,
                                       input logic [CHAR_W-1:0] incoming);
    logic [1:0] ws;
    logic [1:0] wi;
    ws = weight_of(stacked);
    wi = weight_of(incoming);
    if (ws == wi) return stacked != CH_CARET;
    return ws > wi;
  endfunction

  function automatic char_cls_t classify(input logic [CHAR_W-1:0] c);
    char_cls_t k;
    if (c == CH_SPACE) k = CLS_SPACE;
    else if (is_operator(c)) k = CLS_OPER;
    else if (is_operand(c)) k = CLS_OPND;
    else if (c == CH_LPAREN) k = CLS_LPAR;
    else if (c == CH_RPAREN) k = CLS_RPAR;
    else k = CLS_OTHER;
    return k;
  endfunction

endpackage

/* design/itp_if.sv */
// Valid/ready channel interfaces for the converter's input and output words.
// Depends on itp_pkg for widths.
interface itp_in_if;
  import itp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              is_final;

  modport source (output valid, in_char, is_final, input ready);
  modport sink   (input valid, in_char, is_final, output ready);
endinterface

interface itp_out_if;
  import itp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_of_run;
  logic [STAT_W-1:0] status;

  modport source (output valid, out_char, last_of_run, status, input ready);
  modport sink   (input valid, out_char, last_of_run, status, output ready);
endinterface

/* design/infix_to_postfix_converter.sv */
// Infix to postfix converter built from itp_ctrl and itp_dp; one character per word.
// An operand is taken in S_IDLE, classified in S_DISPATCH and emitted from the output
// word register loaded in S_EMIT_CH. A new input word is taken only once the last one,
// its popped or flushed entries and any closing word are done; output stalls hold it.
// Reset (rst, synchronous): empty stack, counters and flags cleared, idle.
module infix_to_postfix_converter
  import itp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  itp_in_if.sink    in_ch,
  itp_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  itp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_char     (in_ch.in_char),
    .is_final    (in_ch.is_final),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_char    (out_ch.out_char),
    .last_of_run (out_ch.last_of_run),
    .status      (out_ch.status)
  );

endmodule

/* design/itp_dp.sv */
// Datapath: input word register, operator stack memory, paren counters,
// error flags and the output word register.
// Depends on itp_pkg; driven by commands from itp_ctrl.
module itp_dp
  import itp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [CHAR_W-1:0] in_char,
  input  logic              is_final,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              last_of_run,
  output logic [STAT_W-1:0] status
);

  logic [CHAR_W-1:0] mem [STACK_DEPTH];
  logic [CHAR_W-1:0] cur;
  logic              fin;
  logic [CHAR_W-1:0] top;
  logic [SP_W-1:0]   sp;
  logic [SP_W-1:0]   sp_dec;
  logic [PAR_W-1:0]  open_cnt;
  logic [PAR_W-1:0]  close_cnt;
  logic              at_start;
  logic              err_inv;
  logic              err_ovf;
  logic [CNT_W-1:0]  res_cnt;
  logic              room;
  logic              allowed;
  logic              load_out;
  logic              full;
  logic [CHAR_W-1:0] emit_char;
  status_t           close_stat;

  assign sp_dec = sp - 1'b1;
  assign full   = (sp == SP_W'(STACK_DEPTH));
  assign room   = !out_valid || out_ready;

  // Cap results per word, keeping the last slot for the closing word
  assign allowed  = (cmd.sel == SEL_CLOSE) ? (res_cnt < CNT_W'(MAX_RESULTS))
                                           : (res_cnt < CNT_W'(MAX_RESULTS - 1));
  assign load_out = cmd.emit && room && allowed;

  // Status back to the controller
  always_comb begin
    stat.cls        = classify(cur);
    stat.fin        = fin;
    stat.sp_zero    = (sp == '0);
    stat.top_lp     = (top == CH_LPAREN);
    stat.top_before = pops_before(top, cur);
    stat.room       = room;
  end

  // Closing status: overflow ahead of invalid
  always_comb begin
    if (err_ovf) close_stat = ST_OVERFLOW;
    else if (err_inv || open_cnt != close_cnt) close_stat = ST_INVALID;
    else close_stat = ST_OK;
  end

  // Select the emitted character
  always_comb begin
    case (cmd.sel)
      SEL_CHAR:  emit_char = cur;
      SEL_SPACE: emit_char = CH_SPACE;
      SEL_TOP:   emit_char = top;
      SEL_CLOSE: emit_char = CH_NUL;
      default:   emit_char = CH_NUL;
    endcase
  end

  // Stack memory write
  always_ff @(posedge clk) begin
    if (cmd.push && !full) begin
      mem[sp[IDX_W-1:0]] <= cur;
    end
  end

  // Stack memory read of the top entry
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      top <= mem[sp_dec[IDX_W-1:0]];
    end
  end

  // Hold the current word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= in_char;
      fin <= is_final;
    end
  end

  // Output word payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_char    <= emit_char;
      last_of_run <= (cmd.sel == SEL_CLOSE);
      status      <= (cmd.sel == SEL_CLOSE) ? close_stat : ST_OK;
    end
  end

  // Control state: stack pointer, counters, flags, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sp        <= '0;
      open_cnt  <= '0;
      close_cnt <= '0;
      at_start  <= 1'b1;
      err_inv   <= 1'b0;
      err_ovf   <= 1'b0;
      res_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (load_out) res_cnt <= res_cnt + 1'b1;

      if (cmd.load) begin
        res_cnt  <= '0;
        at_start <= 1'b0;
        // Flag a leading multiply or divide and a trailing operator
        if ((at_start && (in_char == CH_MUL || in_char == CH_DIV)) ||
            (is_final && is_operator(in_char))) err_inv <= 1'b1;
        if (in_char == CH_LPAREN) open_cnt <= open_cnt + 1'b1;
        if (in_char == CH_RPAREN) close_cnt <= close_cnt + 1'b1;
      end

      if (cmd.push) begin
        if (full) err_ovf <= 1'b1;
        else sp <= sp + 1'b1;
      end

      if (cmd.pop) sp <= sp_dec;

      // Return to the reset state after the closing word
      if (cmd.clear && room) begin
        sp        <= '0;
        open_cnt  <= '0;
        close_cnt <= '0;
        at_start  <= 1'b1;
        err_inv   <= 1'b0;
        err_ovf   <= 1'b0;
      end
    end
  end

endmodule

/* design/itp_ctrl.sv */
// Controller: sequences dispatch, stack pops and pushes for each input word,
// and the flush and closing word after the final one. Depends on itp_pkg; commands itp_dp.
module itp_ctrl
  import itp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   flush;
  logic   flush_next;
  logic   pop_ok;

  // Stacked operator must leave: always on flush, else by paren or precedence
  assign pop_ok = flush ||
                  (!stat.top_lp && (stat.cls == CLS_RPAR || stat.top_before));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      flush <= 1'b0;
    end else begin
      state <= state_next;
      flush <= flush_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    flush_next = flush;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DISPATCH;
          flush_next = 1'b0;
        end
      end
      S_DISPATCH: begin
        case (stat.cls)
          CLS_OPND:           state_next = S_EMIT_CH;
          CLS_OPER, CLS_RPAR: state_next = S_POP_RD;
          CLS_LPAR:           state_next = S_PUSH;
          default:            state_next = S_FIN_CHK;
        endcase
      end
      S_EMIT_CH: begin
        if (stat.room) state_next = S_FIN_CHK;
      end
      S_POP_RD: begin
        if (!stat.sp_zero) state_next = S_POP_CHK;
        else if (flush) state_next = S_CLOSE;
        else if (stat.cls == CLS_OPER) state_next = S_OP_SP;
        else state_next = S_FIN_CHK;
      end
      S_POP_CHK: begin
        if (pop_ok) state_next = S_POP_SP;
        else if (stat.cls == CLS_RPAR) state_next = S_FIN_CHK;
        else state_next = S_OP_SP;
      end
      S_POP_SP: begin
        if (stat.room) state_next = S_POP_OP;
      end
      S_POP_OP: begin
        if (stat.room) state_next = S_POP_RD;
      end
      S_OP_SP: begin
        if (stat.room) state_next = S_PUSH;
      end
      S_PUSH: begin
        state_next = S_FIN_CHK;
      end
      S_FIN_CHK: begin
        if (stat.fin) begin
          state_next = S_POP_RD;
          flush_next = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CLOSE: begin
        if (stat.room) begin
          state_next = S_IDLE;
          flush_next = 1'b0;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.sel   = SEL_CHAR;
    case (state)
      S_IDLE: begin
        // Hold off input while in reset
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      S_EMIT_CH: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_CHAR;
      end
      S_POP_RD: begin
        cmd.rd = !stat.sp_zero;
      end
      S_POP_CHK: begin
        // Drop the matching open paren
        cmd.pop = !pop_ok && (stat.cls == CLS_RPAR);
      end
      S_POP_SP, S_OP_SP: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_SPACE;
      end
      S_POP_OP: begin
        cmd.emit = 1'b1;
        cmd.sel  = SEL_TOP;
        cmd.pop  = stat.room;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
      end
      S_CLOSE: begin
        cmd.emit  = 1'b1;
        cmd.sel   = SEL_CLOSE;
        cmd.clear = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* design/itp_checker.sv */
// Port-level checks for the infix-to-postfix converter, bound to the top.
// Depends on itp_pkg.
module itp_checker
  import itp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_char,
  input logic              last_of_run,
  input logic [STAT_W-1:0] status
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
                                $stable(last_of_run) && $stable(status))
    else $error("output word changed while stalled");

  // No output word right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Status only on the closing word
  a_stat_close: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> status == ST_OK)
    else $error("status set on a non-closing word");

  // Closing word carries a null character
  a_close_nul: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> out_char == CH_NUL)
    else $error("closing word not null");

  // One word in work at a time
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in work");

endmodule

bind infix_to_postfix_converter itp_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_char    (out_ch.out_char),
  .last_of_run (out_ch.last_of_run),
  .status      (out_ch.status)
);
